// ----- src/ppmp_pkg.sv -----
// Shared types, codes and constants of the peer-probe message parser.
`default_nettype none

package ppmp_pkg;

	localparam int CFG_IDX_W = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PING_TYPE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PONG_TYPE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALL_TYPE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_EP    = 8'd3;

	// Result kinds.
	localparam logic [3:0] KIND_HEADER  = 4'd0;
	localparam logic [3:0] KIND_TXID    = 4'd1;
	localparam logic [3:0] KIND_KEY_PAD = 4'd2;
	localparam logic [3:0] KIND_PONG_AD = 4'd3;
	localparam logic [3:0] KIND_PONG_PT = 4'd4;
	localparam logic [3:0] KIND_EP_ADDR = 4'd5;
	localparam logic [3:0] KIND_EP_PORT = 4'd6;
	localparam logic [3:0] KIND_IGNORED = 4'd7;
	localparam logic [3:0] KIND_SUMMARY = 4'd8;

	// Summary status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// Field sizes in bytes and counter limits; the message fields are at the width of the byte counter.
	localparam logic [10:0] HDR_BYTES  = 11'd2;
	localparam logic [10:0] KEY_BYTES  = 11'd32;
	localparam logic [10:0] ADDR_BYTES = 11'd16;
	localparam logic [10:0] PORT_BYTES = 11'd2;
	localparam logic [4:0]  EP_BYTES   = 5'd18;
	localparam logic [4:0]  EP_ADDR_B  = 5'd16;
	localparam logic [5:0]  DROP_MAX   = 6'd63;
	localparam logic [7:0]  SEEN_MAX   = 8'd255;

	typedef enum logic [1:0] {
		TC_PING,
		TC_PONG,
		TC_CALL,
		TC_UNKNOWN
	} tclass_t;

	typedef struct packed {
		logic [7:0] ping_type;
		logic [7:0] pong_type;
		logic [7:0] call_type;
		logic [7:0] max_ep;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  byte_value;
		logic [4:0]  field_offset;
		logic [7:0]  endpoint_index;
		logic [1:0]  status;
		logic [7:0]  message_type;
		logic        has_node_key;
		logic [10:0] padding_length;
		logic [7:0]  endpoint_count;
		logic [5:0]  dropped_count;
		logic        last_result;
	} res_t;

	// Results of one byte: its classification and, on the last byte, the summary.
	typedef struct packed {
		res_t cls;
		res_t sum;
		logic has_sum;
	} res_pair_t;

	// Ping is tested first, then pong, then call.
	function automatic tclass_t type_class(input logic [7:0] t, input cfg_t c);
		tclass_t tc;
		if (t == c.ping_type) begin
			tc = TC_PING;
		end else if (t == c.pong_type) begin
			tc = TC_PONG;
		end else if (t == c.call_type) begin
			tc = TC_CALL;
		end else begin
			tc = TC_UNKNOWN;
		end
		return tc;
	endfunction

endpackage

`default_nettype wire

// ----- src/ppmp_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none

interface ppmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ppmp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  byte_value;
	logic [4:0]  field_offset;
	logic [7:0]  endpoint_index;
	logic [1:0]  status;
	logic [7:0]  message_type;
	logic        has_node_key;
	logic [10:0] padding_length;
	logic [7:0]  endpoint_count;
	logic [5:0]  dropped_count;
	logic        last_result;

	modport source (output valid, output kind, output byte_value, output field_offset,
		output endpoint_index, output status, output message_type, output has_node_key,
		output padding_length, output endpoint_count, output dropped_count,
		output last_result, input ready);
	modport sink (input valid, input kind, input byte_value, input field_offset,
		input endpoint_index, input status, input message_type, input has_node_key,
		input padding_length, input endpoint_count, input dropped_count,
		input last_result, output ready);
endinterface

interface ppmp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/peer_probe_message_parser.sv -----
// Top level of the peer-probe message parser.
// The parser takes a decrypted peer-discovery message one word per byte on in_ch, with
// end_of_message high on the final byte, and gives on res_ch one classification word for
// every byte, followed on the final byte by a summary word with last_result set. A byte
// first lands in an input register; once the queue has room, a single pass of logic
// classifies it against the per-message counters and, on the last byte, forms the
// summary, and the results go into a four-entry result queue that drives res_ch. With
// res_ch always ready, one byte is accepted every cycle while the queue has room; a final
// byte puts two words into the queue, so the result side falls behind by one word per
// message, and the queue absorbs this until it lacks room. Input is held back only while
// the queue lacks room for two words.
// Configuration words on cfg_ch are accepted in every cycle and should be written while no
// message is in flight. There is no clearing pass after reset.
`default_nettype none

module peer_probe_message_parser import ppmp_pkg::*; #(
	parameter int TXID_BYTES        = 12,
	parameter int MAX_MESSAGE_BYTES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	ppmp_in_if.sink   in_ch,
	ppmp_res_if.source res_ch,
	ppmp_cfg_if.sink  cfg_ch
);

	cfg_t       cfg;
	res_pair_t  pair;
	res_t       out_res;
	logic       room;
	logic       adv;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Configuration registers; the write channel never stalls.
	assign cfg_ch.ready = 1'b1;

	ppmp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data  (cfg_ch.data),
		.cfg      (cfg)
	);

	// The byte in the input register is processed once the queue has room for
	// both of its possible results; the register refills in the same cycle.
	assign adv         = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.end_of_message;
		end
	end

	ppmp_core #(
		.TXID_BYTES        (TXID_BYTES),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.data_byte (byte_s1),
		.last      (last_s1),
		.cfg       (cfg),
		.pair      (pair)
	);

	ppmp_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.pair      (pair),
		.room      (room),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.out_res   (out_res)
	);

	assign res_ch.kind           = out_res.kind;
	assign res_ch.byte_value     = out_res.byte_value;
	assign res_ch.field_offset   = out_res.field_offset;
	assign res_ch.endpoint_index = out_res.endpoint_index;
	assign res_ch.status         = out_res.status;
	assign res_ch.message_type   = out_res.message_type;
	assign res_ch.has_node_key   = out_res.has_node_key;
	assign res_ch.padding_length = out_res.padding_length;
	assign res_ch.endpoint_count = out_res.endpoint_count;
	assign res_ch.dropped_count  = out_res.dropped_count;
	assign res_ch.last_result    = out_res.last_result;

endmodule

`default_nettype wire

// ----- src/ppmp_cfg.sv -----
// Configuration registers of the peer-probe message parser.
`default_nettype none

module ppmp_cfg import ppmp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [7:0]           wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ping_type <= 8'd1;
			cfg_q.pong_type <= 8'd2;
			cfg_q.call_type <= 8'd3;
			cfg_q.max_ep    <= 8'd8;
		end else if (wr_en) begin
			// Writes to indexes past the register list are dropped.
			unique case (wr_index)
				REG_PING_TYPE: cfg_q.ping_type <= wr_data;
				REG_PONG_TYPE: cfg_q.pong_type <= wr_data;
				REG_CALL_TYPE: cfg_q.call_type <= wr_data;
				REG_MAX_EP:    cfg_q.max_ep    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- src/ppmp_core.sv -----
// Per-message state and the single-pass byte classifier with its summary.
`default_nettype none

module ppmp_core import ppmp_pkg::*; #(
	parameter int TXID_BYTES        = 12,
	parameter int MAX_MESSAGE_BYTES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	input  cfg_t            cfg,
	output res_pair_t       pair
);

	localparam logic [10:0] MAX_POS  = 11'(MAX_MESSAGE_BYTES);
	localparam logic [10:0] TX       = 11'(TXID_BYTES);
	localparam logic [10:0] TX_ADDR  = 11'(TXID_BYTES) + ADDR_BYTES;
	localparam logic [10:0] TX_PORT  = 11'(TXID_BYTES) + ADDR_BYTES + PORT_BYTES;

	logic [10:0] pos_q, pos_n;
	logic [7:0]  held_q, held_n;
	logic        keynz_q, keynz_n;
	logic [4:0]  eo_q, eo_n;
	logic [7:0]  seen_q, seen_n;
	logic [5:0]  drop_q, drop_n;

	logic        in_range;
	logic [10:0] r, k;
	logic [4:0]  eo_inc;
	tclass_t     tc;
	res_t        cls, sum;
	logic [10:0] rem, after;

	assign in_range = pos_q < MAX_POS;
	assign r        = pos_q - HDR_BYTES;
	assign k        = r - TX;
	assign eo_inc   = eo_q + 5'd1;
	assign held_n   = (in_range && pos_q == 11'd0) ? data_byte : held_q;
	assign tc       = type_class(held_n, cfg);
	assign pos_n    = in_range ? pos_q + 11'd1 : pos_q;

	// Classification of the byte and the next per-message state.
	always_comb begin
		cls            = '0;
		cls.kind       = KIND_IGNORED;
		cls.byte_value = data_byte;
		keynz_n        = keynz_q;
		eo_n           = eo_q;
		seen_n         = seen_q;
		drop_n         = drop_q;
		if (in_range) begin
			if (pos_q < HDR_BYTES) begin
				cls.kind         = KIND_HEADER;
				cls.field_offset = pos_q[4:0];
			end else begin
				unique case (tc)
					TC_PING: begin
						if (r < TX) begin
							cls.kind         = KIND_TXID;
							cls.field_offset = r[4:0];
						end else begin
							cls.kind         = KIND_KEY_PAD;
							cls.field_offset = k[4:0];
							if (k < KEY_BYTES && data_byte != 8'd0) begin
								keynz_n = 1'b1;
							end
						end
					end
					TC_PONG: begin
						if (r < TX) begin
							cls.kind         = KIND_TXID;
							cls.field_offset = r[4:0];
						end else if (r < TX_ADDR) begin
							cls.kind         = KIND_PONG_AD;
							cls.field_offset = k[4:0];
						end else if (r < TX_PORT) begin
							cls.kind         = KIND_PONG_PT;
							cls.field_offset = 5'(r - TX_ADDR);
						end
					end
					TC_CALL: begin
						cls.endpoint_index = seen_q;
						if (eo_q < EP_ADDR_B) begin
							cls.kind         = KIND_EP_ADDR;
							cls.field_offset = eo_q;
						end else begin
							cls.kind         = KIND_EP_PORT;
							cls.field_offset = eo_q - EP_ADDR_B;
						end
						if (eo_inc >= EP_BYTES) begin
							eo_n = 5'd0;
							if (seen_q >= cfg.max_ep && drop_q < DROP_MAX) begin
								drop_n = drop_q + 6'd1;
							end
							if (seen_q < SEEN_MAX) begin
								seen_n = seen_q + 8'd1;
							end
						end else begin
							eo_n = eo_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign rem   = pos_n - HDR_BYTES;
	assign after = rem - TX;

	// Summary, taken from the state as it stands after this byte.
	always_comb begin
		sum              = '0;
		sum.kind         = KIND_SUMMARY;
		sum.message_type = held_n;
		sum.last_result  = 1'b1;
		if (pos_n < HDR_BYTES) begin
			sum.status = ST_SHORT;
		end else begin
			unique case (tc)
				TC_PING: begin
					if (rem < TX) begin
						sum.status = ST_SHORT;
					end else if (after >= KEY_BYTES && keynz_n) begin
						sum.has_node_key   = 1'b1;
						sum.padding_length = after - KEY_BYTES;
					end else begin
						sum.padding_length = after;
					end
				end
				TC_PONG: begin
					if (rem < TX_PORT) begin
						sum.status = ST_SHORT;
					end
				end
				TC_CALL: begin
					// A payload that is not whole endpoints reports no endpoints.
					if (eo_n == 5'd0) begin
						sum.endpoint_count = (seen_n < cfg.max_ep) ? seen_n : cfg.max_ep;
						sum.dropped_count  = drop_n;
					end
				end
				TC_UNKNOWN: sum.status = ST_UNKNOWN;
			endcase
		end
	end

	assign pair.cls     = cls;
	assign pair.sum     = sum;
	assign pair.has_sum = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			held_q  <= '0;
			keynz_q <= 1'b0;
			eo_q    <= '0;
			seen_q  <= '0;
			drop_q  <= '0;
		end else if (adv) begin
			if (last) begin
				pos_q   <= '0;
				held_q  <= '0;
				keynz_q <= 1'b0;
				eo_q    <= '0;
				seen_q  <= '0;
				drop_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				held_q  <= held_n;
				keynz_q <= keynz_n;
				eo_q    <= eo_n;
				seen_q  <= seen_n;
				drop_q  <= drop_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/ppmp_res_fifo.sv -----
// Four-entry result queue that takes one or two results a cycle and gives one.
`default_nettype none

module ppmp_res_fifo import ppmp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_pair_t pair,
	output logic      room,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	res_t       mem_q [4];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q;
	logic       pop;
	logic [2:0] n_push;

	// Room for the worst case of two results.
	assign room      = count_q <= 3'd2;
	assign out_valid = count_q != 3'd0;
	assign out_res   = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push ? (pair.has_sum ? 3'd2 : 3'd1) : 3'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= pair.cls;
			if (pair.has_sum) begin
				mem_q[tail_q + 2'd1] <= pair.sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			tail_q  <= tail_q + n_push[1:0];
			count_q <= count_q + n_push - {2'd0, pop};
		end
	end

endmodule

`default_nettype wire

// ----- src/ppmp_checker.sv -----
// Port-level checks of the peer-probe message parser and their binding.
`default_nettype none

module ppmp_checker import ppmp_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] kind,
	input wire logic [7:0] byte_value,
	input wire logic [4:0] field_offset,
	input wire logic [1:0] status,
	input wire logic       last_result
);

	// A stalled result word stays valid and keeps its kind and byte value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(byte_value))
		else $error("result word changed while stalled");

	// Only the summary ends a message.
	a_last_is_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> kind == KIND_SUMMARY)
		else $error("last_result on a non-summary word");

	// Classification words carry no summary status.
	a_cls_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SUMMARY |-> status == ST_OK && !last_result)
		else $error("summary fields set on a classification word");

	// Summaries carry no byte or offset.
	a_sum_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SUMMARY |-> byte_value == 8'd0 && field_offset == 5'd0
			&& last_result)
		else $error("summary word malformed");

endmodule

bind peer_probe_message_parser ppmp_checker u_ppmp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res_ch.valid),
	.out_ready    (res_ch.ready),
	.kind         (res_ch.kind),
	.byte_value   (res_ch.byte_value),
	.field_offset (res_ch.field_offset),
	.status       (res_ch.status),
	.last_result  (res_ch.last_result)
);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the peer-probe message parser: directed table, random messages.
`default_nettype none

module testbench;
	import ppmp_pkg::*;

	// The parser is built with its default field sizes, and the predictor uses the same.
	localparam int TXID_LEN        = 12;
	localparam int MSG_LIMIT       = 1024;
	localparam int ENDPOINT_LEN    = 18;
	localparam int RESET_CYCLES    = 7;
	// A word reaches res_ch through the input register and the result queue, so a short tail covers it.
	localparam int TAIL_CYCLES     = 8;
	localparam int PHASE_ITEMS     = 225;
	localparam int PHASE_COUNT     = 6;
	localparam int HOLD_OFF_CYCLES = 300;
	// Longest quiet stretch of a correct run is the hold-off above; the limit is ten times it.
	localparam int IDLE_LIMIT      = 3000;
	localparam int REPORT_LINES    = 100;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ppmp_in_if  in_ch ();
	ppmp_res_if res_ch ();
	ppmp_cfg_if cfg_ch ();

	peer_probe_message_parser #(
		.TXID_BYTES       (TXID_LEN),
		.MAX_MESSAGE_BYTES(MSG_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.res_ch(res_ch),
		.cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	// One row of the directed table. When typed is set, the summary word of that byte is the
	// one written in the row instead of the one the predictor works out.
	typedef struct {
		logic [7:0] b;
		logic       eom;
		logic       typed;
		res_t       sum;
	} row_t;

	row_t steps [$];

	// Words the parser still owes, oldest first.
	res_t pending_words [$];

	// Predictor state: the per-message counters and the register values it has seen written.
	cfg_t        model_cfg;
	logic [10:0] pos_count;
	logic [7:0]  msg_type_q;
	logic        key_seen;
	logic [4:0]  ep_off;
	logic [7:0]  ep_seen;
	logic [5:0]  ep_drop;

	// Register values that the stimulus side last wrote, used to pick type bytes.
	cfg_t phase_cfg;

	// Side band that travels with each input word, so the monitor knows of a typed summary.
	logic tag_typed;
	res_t tag_sum;

	logic [7:0] msg_bytes [$];
	res_t       seen_word;
	logic       hold_off_req = 1'b0;
	int         error_count  = 0;
	int         words_checked = 0;
	int         items_sent   = 0;
	int         idle_cycles  = 0;
	int         burst_left   = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		// Keep the log short when the parser is badly off; every mismatch still counts.
		if (error_count < REPORT_LINES) begin
			$display("mismatch at word %0d: %s got %0h want %0h", words_checked, what, got,
				want);
		end
		error_count++;
	endtask

	task automatic check_word(input res_t got, input res_t want);
		if (got.kind !== want.kind)
			report_mismatch("kind", got.kind, want.kind);
		if (got.byte_value !== want.byte_value)
			report_mismatch("byte_value", got.byte_value, want.byte_value);
		if (got.field_offset !== want.field_offset)
			report_mismatch("field_offset", got.field_offset, want.field_offset);
		if (got.endpoint_index !== want.endpoint_index)
			report_mismatch("endpoint_index", got.endpoint_index, want.endpoint_index);
		if (got.status !== want.status)
			report_mismatch("status", got.status, want.status);
		if (got.message_type !== want.message_type)
			report_mismatch("message_type", got.message_type, want.message_type);
		if (got.has_node_key !== want.has_node_key)
			report_mismatch("has_node_key", got.has_node_key, want.has_node_key);
		if (got.padding_length !== want.padding_length)
			report_mismatch("padding_length", got.padding_length, want.padding_length);
		if (got.endpoint_count !== want.endpoint_count)
			report_mismatch("endpoint_count", got.endpoint_count, want.endpoint_count);
		if (got.dropped_count !== want.dropped_count)
			report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
		if (got.last_result !== want.last_result)
			report_mismatch("last_result", got.last_result, want.last_result);
	endtask

	function automatic res_t summary_word(input logic [7:0] t, input logic [1:0] st);
		res_t w;
		w = '0;
		w.kind = KIND_SUMMARY;
		w.message_type = t;
		w.status = st;
		w.last_result = 1'b1;
		return w;
	endfunction

	// Colliding codes resolve in the order ping, pong, call.
	function automatic tclass_t class_of(input logic [7:0] t);
		return (t == model_cfg.ping_type) ? TC_PING :
			(t == model_cfg.pong_type) ? TC_PONG :
			(t == model_cfg.call_type) ? TC_CALL : TC_UNKNOWN;
	endfunction

	task automatic clear_message_state();
		pos_count = '0;
		msg_type_q = '0;
		key_seen = 1'b0;
		ep_off = '0;
		ep_seen = '0;
		ep_drop = '0;
	endtask

	// Works out the classification word of one accepted byte and, on the last byte of a
	// message, the summary word, and queues them in the order the parser gives them.
	task automatic classify_byte(input logic [7:0] b, input logic eom);
		res_t    cls;
		res_t    sum;
		tclass_t tc;
		int      r;
		int      k;
		cls = '0;
		cls.kind = KIND_IGNORED;
		cls.byte_value = b;
		// Bytes past the length limit are ignored and leave every counter alone.
		if (pos_count < MSG_LIMIT) begin
			if (pos_count == 0)
				msg_type_q = b;
			if (pos_count < HDR_BYTES) begin
				cls.kind = KIND_HEADER;
				cls.field_offset = pos_count[4:0];
			end else begin
				r = int'(pos_count) - int'(HDR_BYTES);
				tc = class_of(msg_type_q);
				case (tc)
					TC_PING: begin
						if (r < TXID_LEN) begin
							cls.kind = KIND_TXID;
							cls.field_offset = r[4:0];
						end else begin
							// Key and padding share one kind; the offset wraps every 32 bytes.
							k = r - TXID_LEN;
							cls.kind = KIND_KEY_PAD;
							cls.field_offset = k[4:0];
							if (k < KEY_BYTES && b != 8'd0)
								key_seen = 1'b1;
						end
					end
					TC_PONG: begin
						if (r < TXID_LEN) begin
							cls.kind = KIND_TXID;
							cls.field_offset = r[4:0];
						end else if (r < TXID_LEN + ADDR_BYTES) begin
							cls.kind = KIND_PONG_AD;
							k = r - TXID_LEN;
							cls.field_offset = k[4:0];
						end else if (r < TXID_LEN + ADDR_BYTES + PORT_BYTES) begin
							cls.kind = KIND_PONG_PT;
							k = r - TXID_LEN - ADDR_BYTES;
							cls.field_offset = k[4:0];
						end
						// Anything after the port stays ignored.
					end
					TC_CALL: begin
						if (ep_off < EP_ADDR_B) begin
							cls.kind = KIND_EP_ADDR;
							cls.field_offset = ep_off;
						end else begin
							cls.kind = KIND_EP_PORT;
							cls.field_offset = ep_off - EP_ADDR_B;
						end
						cls.endpoint_index = ep_seen;
						if (ep_off == EP_BYTES - 5'd1) begin
							// An endpoint is complete; past the limit it counts as dropped.
							ep_off = '0;
							if (ep_seen >= model_cfg.max_ep && ep_drop < DROP_MAX)
								ep_drop = ep_drop + 6'd1;
							if (ep_seen < SEEN_MAX)
								ep_seen = ep_seen + 8'd1;
						end else begin
							ep_off = ep_off + 5'd1;
						end
					end
					default: begin
					end
				endcase
			end
			pos_count = pos_count + 11'd1;
		end
		pending_words.push_back(cls);

		if (eom) begin
			sum = summary_word(msg_type_q, ST_OK);
			if (pos_count < HDR_BYTES) begin
				sum.status = ST_SHORT;
			end else begin
				r = int'(pos_count) - int'(HDR_BYTES);
				tc = class_of(msg_type_q);
				case (tc)
					TC_PING: begin
						if (r < TXID_LEN) begin
							sum.status = ST_SHORT;
						end else begin
							k = r - TXID_LEN;
							// Only a full, nonzero key window counts as a node key.
							if (k >= KEY_BYTES && key_seen) begin
								sum.has_node_key = 1'b1;
								k = k - KEY_BYTES;
							end
							sum.padding_length = k[10:0];
						end
					end
					TC_PONG: begin
						if (r < TXID_LEN + ADDR_BYTES + PORT_BYTES)
							sum.status = ST_SHORT;
					end
					TC_CALL: begin
						// A payload that is not whole endpoints reports no endpoints at all.
						if (ep_off == 5'd0) begin
							sum.endpoint_count = (ep_seen < model_cfg.max_ep) ? ep_seen :
								model_cfg.max_ep;
							sum.dropped_count = ep_drop;
						end
					end
					default: sum.status = ST_UNKNOWN;
				endcase
			end
			pending_words.push_back(sum);
			clear_message_state();
		end
	endtask

	// Monitor: follows register writes, checks every result word against the oldest
	// expectation and runs the predictor on every accepted input word. All reads here see
	// the values from before the edge, so the order of processes within a step does not
	// matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_PING_TYPE: model_cfg.ping_type = cfg_ch.data;
					REG_PONG_TYPE: model_cfg.pong_type = cfg_ch.data;
					REG_CALL_TYPE: model_cfg.call_type = cfg_ch.data;
					REG_MAX_EP:    model_cfg.max_ep = cfg_ch.data;
					default: begin
					end
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				seen_word.kind = res_ch.kind;
				seen_word.byte_value = res_ch.byte_value;
				seen_word.field_offset = res_ch.field_offset;
				seen_word.endpoint_index = res_ch.endpoint_index;
				seen_word.status = res_ch.status;
				seen_word.message_type = res_ch.message_type;
				seen_word.has_node_key = res_ch.has_node_key;
				seen_word.padding_length = res_ch.padding_length;
				seen_word.endpoint_count = res_ch.endpoint_count;
				seen_word.dropped_count = res_ch.dropped_count;
				seen_word.last_result = res_ch.last_result;
				if (pending_words.size() == 0)
					report_mismatch("result with nothing pending", seen_word.kind, 0);
				else
					check_word(seen_word, pending_words.pop_front());
				words_checked++;
			end
			if (in_ch.valid && in_ch.ready) begin
				classify_byte(in_ch.data_byte, in_ch.end_of_message);
				// A typed row replaces the predicted summary with the one written in the table.
				if (tag_typed && in_ch.end_of_message) begin
					void'(pending_words.pop_back());
					pending_words.push_back(tag_sum);
				end
			end
			if ((cfg_ch.valid && cfg_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(in_ch.valid && in_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Watchdog: a run in which no channel moves for this long has hung.
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	// Result side: stretches of random length, each with its own stall pattern. On request it
	// holds ready low for a long stretch so that the result queue fills and input stalls.
	initial begin : result_sink
		int   stretch_mode;
		int   stretch_len;
		int   pattern_tick;
		logic ready_next;
		pattern_tick = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stretch_mode = $urandom_range(0, 3);
			stretch_len = $urandom_range(10, 150);
			repeat (stretch_len) begin
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					res_ch.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
				end
				pattern_tick++;
				case (stretch_mode)
					0: ready_next = 1'b1;
					1: ready_next = $urandom_range(0, 1);
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = (pattern_tick % 3 != 0);
				endcase
				res_ch.ready <= ready_next;
				@(posedge clk);
			end
		end
	end

	// Offers one word and returns at the edge that takes it. The sender works in bursts; a
	// nonzero gap between bursts drops valid, while back-to-back words keep it high throughout.
	task automatic offer(input logic [7:0] b, input logic eom, input logic typed,
			input res_t sum);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) :
				$urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_message <= eom;
		tag_typed <= typed;
		tag_sum <= sum;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		items_sent++;
	endtask

	// Stops input and waits until every owed word has come, plus the pipeline latency.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Writes all four registers back to back; valid drops only after the last one.
	task automatic load_config(input cfg_t c);
		logic [7:0] idx;
		logic [7:0] val;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0: begin idx = REG_PING_TYPE; val = c.ping_type; end
				1: begin idx = REG_PONG_TYPE; val = c.pong_type; end
				2: begin idx = REG_CALL_TYPE; val = c.call_type; end
				default: begin idx = REG_MAX_EP; val = c.max_ep; end
			endcase
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data <= val;
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		phase_cfg = c;
	endtask

	task automatic add_row(input logic [7:0] b, input logic eom, input logic typed,
			input res_t sum);
		row_t row;
		row.b = b;
		row.eom = eom;
		row.typed = typed;
		row.sum = sum;
		steps.push_back(row);
	endtask

	// Sends random messages until the phase has used its share of words. Most are well
	// formed with random content; the rest are short, malformed, unknown or plain noise.
	// With long_one set, the phase ends with one ping that runs past the length limit.
	task automatic run_phase(input int budget, input logic long_one);
		int         stop_at;
		int         pick;
		int         n;
		logic [7:0] t;
		stop_at = items_sent + budget;
		while (items_sent < stop_at || long_one) begin
			msg_bytes.delete();
			pick = $urandom_range(0, 99);
			if (items_sent >= stop_at)
				pick = 100;
			if (pick < 30 || pick == 100) begin
				// Ping: id, then a key window that is random, zero, partial or nonzero only
				// at its last byte, then mostly zero padding.
				msg_bytes.push_back(phase_cfg.ping_type);
				msg_bytes.push_back($urandom_range(0, 255));
				repeat (TXID_LEN) msg_bytes.push_back($urandom_range(0, 255));
				case ((pick == 100) ? 0 : $urandom_range(0, 3))
					0: begin
						repeat (KEY_BYTES) msg_bytes.push_back($urandom_range(0, 255));
						n = HDR_BYTES + TXID_LEN + $urandom_range(0, KEY_BYTES - 1);
						msg_bytes[n] = $urandom_range(1, 255);
					end
					1: repeat (KEY_BYTES) msg_bytes.push_back(8'd0);
					2: repeat ($urandom_range(0, KEY_BYTES - 1))
						msg_bytes.push_back($urandom_range(0, 1) ? 8'd0 : $urandom_range(0, 255));
					default: begin
						repeat (KEY_BYTES - 1) msg_bytes.push_back(8'd0);
						msg_bytes.push_back($urandom_range(1, 255));
					end
				endcase
				if (pick == 100) begin
					n = MSG_LIMIT + $urandom_range(1, 8);
					while (msg_bytes.size() < n)
						msg_bytes.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
					long_one = 1'b0;
				end else begin
					repeat ($urandom_range(0, 20))
						msg_bytes.push_back($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
					if ($urandom_range(0, 9) == 0) begin
						n = $urandom_range(HDR_BYTES, HDR_BYTES + TXID_LEN - 1);
						while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
					end
				end
			end else if (pick < 50) begin
				// Pong: exact length, with a tail, or cut short.
				msg_bytes.push_back(phase_cfg.pong_type);
				repeat (1 + TXID_LEN + ADDR_BYTES + PORT_BYTES)
					msg_bytes.push_back($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 6)) msg_bytes.push_back($urandom_range(0, 255));
				else if ($urandom_range(0, 5) == 0) begin
					n = $urandom_range(HDR_BYTES, HDR_BYTES + TXID_LEN + ADDR_BYTES + 1);
					while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
				end
			end else if (pick < 75) begin
				// Endpoint list: mostly a few endpoints, sometimes enough to pass the limit,
				// sometimes a length that is not whole endpoints.
				msg_bytes.push_back(phase_cfg.call_type);
				msg_bytes.push_back($urandom_range(0, 255));
				n = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
				repeat (n * ENDPOINT_LEN) msg_bytes.push_back($urandom_range(0, 255));
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, ENDPOINT_LEN - 1))
						msg_bytes.push_back($urandom_range(0, 255));
			end else if (pick < 85) begin
				// Unknown type: any byte that matches none of the three codes.
				do t = $urandom_range(0, 255);
				while (t == phase_cfg.ping_type || t == phase_cfg.pong_type ||
					t == phase_cfg.call_type);
				msg_bytes.push_back(t);
				repeat ($urandom_range(0, 9)) msg_bytes.push_back($urandom_range(0, 255));
			end else if (pick < 90) begin
				msg_bytes.push_back($urandom_range(0, 255));
			end else begin
				// Noise, half of it under a known type byte.
				case ($urandom_range(0, 5))
					0: msg_bytes.push_back(phase_cfg.ping_type);
					1: msg_bytes.push_back(phase_cfg.pong_type);
					2: msg_bytes.push_back(phase_cfg.call_type);
					default: msg_bytes.push_back($urandom_range(0, 255));
				endcase
				repeat ($urandom_range(0, 39)) msg_bytes.push_back($urandom_range(0, 255));
			end
			foreach (msg_bytes[i])
				offer(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
		end
	endtask

	initial begin
		cfg_t c;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_of_message = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		tag_typed = 1'b0;
		tag_sum = '0;
		// Register values after reset.
		model_cfg.ping_type = 8'd1;
		model_cfg.pong_type = 8'd2;
		model_cfg.call_type = 8'd3;
		model_cfg.max_ep = 8'd8;
		phase_cfg = model_cfg;
		clear_message_state();

		// Directed messages under the reset codes. The summaries of these can be read off
		// directly, so they are written out; the byte words come from the predictor.
		// A message of one byte is too short and reports that byte as its type.
		add_row(8'hFF, 1'b1, 1'b1, summary_word(8'hFF, ST_SHORT));
		// Unknown type, with the header extremes and a byte after the header.
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'h55, 1'b1, 1'b1, summary_word(8'h00, ST_UNKNOWN));
		// Ping with only a header, then a ping cut off inside its id.
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b1, summary_word(8'h01, ST_SHORT));
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h7F, 1'b0, 1'b0, '0);
		add_row(8'h80, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b1, 1'b1, summary_word(8'h01, ST_SHORT));
		// Pong cut off inside its id.
		add_row(8'h02, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b1, 1'b1, summary_word(8'h02, ST_SHORT));
		// Endpoint list with an empty payload, then one whose length is not whole
		// endpoints: both are fine and report no endpoints.
		add_row(8'h03, 1'b0, 1'b0, '0);
		add_row(8'hAA, 1'b1, 1'b1, summary_word(8'h03, ST_OK));
		add_row(8'h03, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'h12, 1'b1, 1'b1, summary_word(8'h03, ST_OK));
		// Known types that stop after their type byte.
		add_row(8'h02, 1'b1, 1'b1, summary_word(8'h02, ST_SHORT));
		add_row(8'h03, 1'b1, 1'b1, summary_word(8'h03, ST_SHORT));

		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (steps[i])
			offer(steps[i].b, steps[i].eom, steps[i].typed, steps[i].sum);
		drain();

		// Random phases. The first runs on the reset values and ends with the overlong
		// message; the others cover the code extremes, codes that collide, and random codes.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: c = phase_cfg;
				1: c = '{ping_type: 8'd0, pong_type: 8'd255, call_type: 8'd128, max_ep: 8'd0};
				2: c = '{ping_type: 8'd255, pong_type: 8'd0, call_type: 8'd7, max_ep: 8'd255};
				// All three codes the same: pings, pongs and endpoint lists all parse as pings.
				3: c = '{ping_type: 8'd5, pong_type: 8'd5, call_type: 8'd5, max_ep: 8'd2};
				// Pong and call share a code: endpoint lists parse as pongs.
				4: c = '{ping_type: 8'd9, pong_type: 8'd4, call_type: 8'd4, max_ep: 8'd1};
				default: begin
					c.ping_type = $urandom_range(0, 255);
					c.pong_type = $urandom_range(0, 255);
					c.call_type = $urandom_range(0, 255);
					c.max_ep = $urandom_range(0, 6);
				end
			endcase
			if (p != 0)
				load_config(c);
			if (p == 0 || p == 3)
				hold_off_req = 1'b1;
			run_phase(PHASE_ITEMS, p == 0);
			drain();
		end

		if (pending_words.size() != 0)
			report_mismatch("words never delivered", pending_words.size(), 0);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
